[rtl/core/ipdu_pkg.sv]
// Package with shared types, constants and helpers for the implicit drag update block.
`timescale 1ns / 1ps
`default_nettype none
package ipdu_pkg;

  localparam int unsigned OneQ16 = 65536;
  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = -32'sh7FFF_FFFF - 32'sh1;

  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_EXPLICIT = 2'd1,
    KIND_IMPLICIT = 2'd2,
    KIND_OUTSIDE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_USE_CN    = 2'd0,
    REG_ALPHA     = 2'd1,
    REG_ADDED_MASS = 2'd2,
    REG_HALF_STEP = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MA,
    ST_QDIV,
    ST_K,
    ST_DEN,
    ST_D,
    ST_NUM,
    ST_VDIV,
    ST_DU,
    ST_FRC,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [95:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [95:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [97:0] x);
    logic signed [31:0] r;
    if (x > 98'(signed'(S32Max))) r = S32Max;
    else if (x < 98'(signed'(S32Min))) r = S32Min;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [97:0] div_q16(input logic signed [97:0] x);
    logic signed [97:0] r;
    r = (x < 0) ? -((-x) >>> 16) : (x >>> 16);
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ipdu_stream_if.sv]
// Valid/ready channel interface with a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface ipdu_stream_if #(parameter int unsigned Width = 32);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ipdu_divider.sv]
// Iterative restoring divider, one quotient bit per cycle, unsigned.
`timescale 1ns / 1ps
`default_nettype none
module ipdu_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipdu_pkg::div_req_t req,
  output ipdu_pkg::div_rsp_t      rsp
);
  logic [95:0] quo;
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  always_comb begin
    trial = {rem[63:0], quo[95]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd96;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[94:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[94:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 7'd0)
    else $error("divider count underflow");
endmodule
`default_nettype wire

[rtl/core/ipdu_core.sv]
// Sequencer and datapath that drives the shared divider per implicit item and axis.
`timescale 1ns / 1ps
`default_nettype none
module ipdu_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_idx,
  input  wire logic [30:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [351:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [287:0]      out_data
);
  ipdu_pkg::state_t state, state_next;
  ipdu_pkg::div_req_t dreq;
  ipdu_pkg::div_rsp_t drsp;

  logic        use_cn;
  logic [16:0] alpha;
  logic [30:0] amf;
  logic [30:0] hst;
  logic signed [31:0] drag_sum [3];

  logic [30:0] coeff, mass;
  logic signed [31:0] fluid [3];
  logic signed [31:0] part [3];
  logic signed [31:0] force_add [3];
  logic signed [31:0] vel [3];
  logic [1:0]  ax;
  logic [61:0] ma;
  logic [30:0] kreg;
  logic [47:0] den;
  logic signed [97:0] acc;
  logic signed [31:0] dreg;
  logic signed [31:0] vn;
  logic [16:0] a_c;
  logic [16:0] om;
  logic [95:0] qv;
  logic signed [97:0] numq;

  ipdu_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign a_c = (alpha > 17'd65536) ? 17'd65536 : alpha;
  assign om  = 17'd65536 - a_c;
  assign qv  = drsp.quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipdu_pkg::ST_IDLE;
      use_cn <= 1'b0;
      alpha <= '0;
      amf <= 31'd65536;
      hst <= '0;
      for (int i = 0; i < 3; i++) drag_sum[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (ipdu_pkg::reg_idx_t'(cfg_idx))
          ipdu_pkg::REG_USE_CN:     use_cn <= cfg_data[0];
          ipdu_pkg::REG_ALPHA:      alpha <= cfg_data[16:0];
          ipdu_pkg::REG_ADDED_MASS: amf <= cfg_data;
          ipdu_pkg::REG_HALF_STEP:  hst <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ipdu_pkg::ST_IDLE: begin
          if (in_valid) begin
            coeff <= in_data[32:2];
            mass  <= in_data[63:33];
            for (int i = 0; i < 3; i++) begin
              logic signed [97:0] f;
              logic signed [31:0] ex;
              f = '0;
              ex = in_data[256+32*i +: 32];
              if (!use_cn) f = 98'(ipdu_pkg::sat32(ipdu_pkg::div_q16(
                  98'($signed({1'b0, in_data[32:2]})) *
                  (98'($signed(in_data[64+32*i +: 32])) -
                   98'($signed(in_data[160+32*i +: 32]))))));
              fluid[i] <= in_data[64+32*i +: 32];
              part[i]  <= in_data[160+32*i +: 32];
              vel[i]   <= in_data[160+32*i +: 32];
              if (in_data[1:0] == ipdu_pkg::KIND_EXPLICIT) begin
                force_add[i] <= ipdu_pkg::sat32(f + 98'(ex));
                drag_sum[i] <= ipdu_pkg::sat32(98'(ipdu_pkg::sat32(
                    98'(drag_sum[i]) + f)) + 98'(ex));
              end else begin
                force_add[i] <= '0;
                if (in_data[1:0] == ipdu_pkg::KIND_CLEAR) drag_sum[i] <= '0;
              end
            end
            ax <= '0;
          end
        end
        ipdu_pkg::ST_MA: ma <= mass * amf;
        ipdu_pkg::ST_QDIV: ;
        ipdu_pkg::ST_K: begin
          if (ma == '0) acc <= 98'(ipdu_pkg::S32Max);
          else if (qv > 96'h7FFF_FFFF) acc <= 98'(ipdu_pkg::S32Max);
          else acc <= 98'(qv[30:0]);
        end
        ipdu_pkg::ST_DEN: begin
          logic [61:0] kq;
          kq = acc[30:0] * hst;
          kreg <= (kq[61:16] > 46'h7FFF_FFFF) ? 31'h7FFF_FFFF : kq[46:16];
        end
        ipdu_pkg::ST_D: begin
          den <= ((48'(kreg) * 48'(a_c)) >> 16) + 48'd65536;
          dreg <= ipdu_pkg::sat32(98'(fluid[ax]) - ipdu_pkg::div_q16(
                  98'($signed({1'b0, om})) * 98'(part[ax])));
        end
        ipdu_pkg::ST_NUM: begin
          numq <= 98'(part[ax]) + ipdu_pkg::div_q16(98'($signed({1'b0, kreg})) *
                  98'(dreg));
        end
        ipdu_pkg::ST_VDIV: begin
          if (drsp.done) begin
            if (numq < 0)
              vn <= ipdu_pkg::sat32(-98'($signed({1'b0, qv})));
            else
              vn <= ipdu_pkg::sat32(98'($signed({1'b0, qv})));
          end
        end
        ipdu_pkg::ST_DU: begin
          dreg <= ipdu_pkg::sat32(98'(fluid[ax]) - ipdu_pkg::div_q16(
                  98'($signed({1'b0, om})) * 98'(part[ax]) +
                  98'($signed({1'b0, a_c})) * 98'(vn)));
        end
        ipdu_pkg::ST_FRC: begin
          force_add[ax] <= ipdu_pkg::sat32(ipdu_pkg::div_q16(
                           98'($signed({1'b0, coeff})) * 98'(dreg)));
          vel[ax] <= vn;
        end
        ipdu_pkg::ST_SUM: begin
          drag_sum[ax] <= ipdu_pkg::sat32(98'(drag_sum[ax]) + 98'(force_add[ax]));
          ax <= ax + 2'd1;
        end
        ipdu_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [97:0] mag;
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = '0;
    dreq.divisor = '0;
    mag = (numq < 0) ? 98'(-numq) : 98'(numq);
    unique case (state)
      ipdu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data[1:0] == ipdu_pkg::KIND_IMPLICIT && use_cn)
            state_next = ipdu_pkg::ST_MA;
          else state_next = ipdu_pkg::ST_OUT;
        end
      end
      ipdu_pkg::ST_MA: begin
        state_next = ipdu_pkg::ST_QDIV;
      end
      ipdu_pkg::ST_QDIV: begin
        if (ma == '0) state_next = ipdu_pkg::ST_K;
        else begin
          if (!drsp.busy && !drsp.done) begin
            dreq.start = 1'b1;
            dreq.dividend = {33'd0, coeff, 32'd0};
            dreq.divisor = {2'd0, ma};
          end
          if (drsp.done) state_next = ipdu_pkg::ST_K;
        end
      end
      ipdu_pkg::ST_K: state_next = ipdu_pkg::ST_DEN;
      ipdu_pkg::ST_DEN: state_next = ipdu_pkg::ST_D;
      ipdu_pkg::ST_D: state_next = ipdu_pkg::ST_NUM;
      ipdu_pkg::ST_NUM: state_next = ipdu_pkg::ST_VDIV;
      ipdu_pkg::ST_VDIV: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
          dreq.dividend = {mag[79:0], 16'd0};
          dreq.divisor = {16'd0, den};
        end
        if (drsp.done) state_next = ipdu_pkg::ST_DU;
      end
      ipdu_pkg::ST_DU: state_next = ipdu_pkg::ST_FRC;
      ipdu_pkg::ST_FRC: state_next = ipdu_pkg::ST_SUM;
      ipdu_pkg::ST_SUM: state_next = (ax == 2'd2) ? ipdu_pkg::ST_OUT : ipdu_pkg::ST_D;
      ipdu_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ipdu_pkg::ST_IDLE;
      end
      default: state_next = ipdu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_data[32*i +: 32]      = force_add[i];
      out_data[96+32*i +: 32]   = vel[i];
      out_data[192+32*i +: 32]  = drag_sum[i];
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst)
    (state == ipdu_pkg::ST_SUM) |-> ax != 2'd3)
    else $error("axis index out of range");
  assert property (@(posedge clk) disable iff (rst) dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
endmodule
`default_nettype wire

[rtl/core/implicit_particle_drag_update.sv]
// Top level of the implicit particle drag update block.
// Clear, explicit, outside and inactive implicit items: result valid 1 cycle after accept.
// Implicit items with Crank-Nicolson on: result after the shared divider has run one q division
// plus one per axis; the q division is skipped if mass*factor is 0.
// One item is in flight at a time; the next is accepted the cycle after the result is taken.
// Synchronous active-high reset clears the totals and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module implicit_particle_drag_update (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [30:0] cfg_data,
  ipdu_stream_if.sink      in_ch,
  ipdu_stream_if.source    out_ch
);
  ipdu_core u_core (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data[351:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data[287:0])
  );
endmodule
`default_nettype wire

[tb/ipdu_tb_pkg.sv]
// Transaction layouts of the drag update channels as seen by the testbench.
`timescale 1ns / 1ps
package ipdu_tb_pkg;
  import ipdu_pkg::*;

  typedef struct packed {
    logic signed [31:0] extra_force_z;
    logic signed [31:0] extra_force_y;
    logic signed [31:0] extra_force_x;
    logic signed [31:0] part_vel_z;
    logic signed [31:0] part_vel_y;
    logic signed [31:0] part_vel_x;
    logic signed [31:0] fluid_vel_z;
    logic signed [31:0] fluid_vel_y;
    logic signed [31:0] fluid_vel_x;
    logic [30:0]        particle_mass;
    logic [30:0]        drag_coeff;
    kind_t              kind;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] total_z;
    logic signed [31:0] total_y;
    logic signed [31:0] total_x;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] force_add_z;
    logic signed [31:0] force_add_y;
    logic signed [31:0] force_add_x;
  } drag_result_t;

  localparam int unsigned ParticleBits = $bits(particle_t);
  localparam int unsigned ResultBits = $bits(drag_result_t);
endpackage

[tb/drag_update_checker.sv]
// Checker that predicts each drag update result and compares it with the block output.
`timescale 1ns / 1ps
module drag_update_checker
  import ipdu_pkg::*;
  import ipdu_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [ParticleBits-1:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [ResultBits-1:0] out_data,
  output int          errors,
  output int          pending
);

  typedef logic signed [127:0] wide_t;

  logic signed [31:0] drag_total [3];
  logic               cn_on;
  logic [16:0]        alpha;
  logic [30:0]        mass_factor;
  logic [30:0]        half_step;
  drag_result_t       expected_q [$];

  function automatic logic signed [31:0] clamp32(wide_t x);
    if (x > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -128'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic drag_result_t drag_update(particle_t p);
    drag_result_t r;
    logic signed [31:0] fluid [3];
    logic signed [31:0] part [3];
    logic signed [31:0] extra [3];
    logic signed [31:0] frc_o [3];
    logic signed [31:0] vel [3];
    wide_t coeff, ma, q, k, a, om, den, d, num, vn, du, frc;
    fluid = '{p.fluid_vel_x, p.fluid_vel_y, p.fluid_vel_z};
    part = '{p.part_vel_x, p.part_vel_y, p.part_vel_z};
    extra = '{p.extra_force_x, p.extra_force_y, p.extra_force_z};
    coeff = wide_t'(p.drag_coeff);
    for (int i = 0; i < 3; i++) begin
      frc_o[i] = 0;
      vel[i] = part[i];
    end
    if (p.kind == KIND_CLEAR) begin
      for (int i = 0; i < 3; i++) drag_total[i] = 0;
    end else if (p.kind == KIND_EXPLICIT) begin
      for (int i = 0; i < 3; i++) begin
        frc = 0;
        if (!cn_on) frc = clamp32(coeff * (wide_t'(fluid[i]) - wide_t'(part[i])) / 65536);
        frc_o[i] = clamp32(frc + wide_t'(extra[i]));
        drag_total[i] = clamp32(wide_t'(clamp32(wide_t'(drag_total[i]) + frc))
                                + wide_t'(extra[i]));
      end
    end else if (p.kind == KIND_IMPLICIT && cn_on) begin
      ma = wide_t'(p.particle_mass) * wide_t'(mass_factor);
      if (ma == 0) q = 128'sd2147483647;
      else q = (coeff <<< 32) / ma;
      if (q > 128'sd2147483647) q = 128'sd2147483647;
      k = q * wide_t'(half_step) / 65536;
      if (k > 128'sd2147483647) k = 128'sd2147483647;
      a = (alpha > 17'd65536) ? 128'sd65536 : wide_t'(alpha);
      om = 65536 - a;
      den = 65536 + (k * a) / 65536;
      for (int i = 0; i < 3; i++) begin
        d = clamp32(wide_t'(fluid[i]) - (om * wide_t'(part[i])) / 65536);
        num = wide_t'(part[i]) + (k * d) / 65536;
        vn = clamp32((num * 65536) / den);
        du = clamp32(wide_t'(fluid[i]) - (om * wide_t'(part[i]) + a * vn) / 65536);
        frc = clamp32((coeff * du) / 65536);
        vel[i] = vn[31:0];
        frc_o[i] = frc[31:0];
        drag_total[i] = clamp32(wide_t'(drag_total[i]) + frc);
      end
    end
    r.force_add_x = frc_o[0];
    r.force_add_y = frc_o[1];
    r.force_add_z = frc_o[2];
    r.new_vel_x = vel[0];
    r.new_vel_y = vel[1];
    r.new_vel_z = vel[2];
    r.total_x = drag_total[0];
    r.total_y = drag_total[1];
    r.total_z = drag_total[2];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    drag_result_t e, g;
    if (rst) begin
      for (int i = 0; i < 3; i++) drag_total[i] = 0;
      cn_on = 1'b0;
      alpha = '0;
      mass_factor = 31'd65536;
      half_step = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_USE_CN:     cn_on = cfg_data[0];
          REG_ALPHA:      alpha = cfg_data[16:0];
          REG_ADDED_MASS: mass_factor = cfg_data;
          REG_HALF_STEP:  half_step = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(drag_update(particle_t'(in_data)));
      if (out_valid && out_ready) begin
        g = drag_result_t'(out_data);
        if (expected_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          errors++;
        end else begin
          e = expected_q.pop_front();
          compare_field("force_add_x", e.force_add_x, g.force_add_x);
          compare_field("force_add_y", e.force_add_y, g.force_add_y);
          compare_field("force_add_z", e.force_add_z, g.force_add_z);
          compare_field("new_vel_x", e.new_vel_x, g.new_vel_x);
          compare_field("new_vel_y", e.new_vel_y, g.new_vel_y);
          compare_field("new_vel_z", e.new_vel_z, g.new_vel_z);
          compare_field("total_x", e.total_x, g.total_x);
          compare_field("total_y", e.total_y, g.total_y);
          compare_field("total_z", e.total_z, g.total_z);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

[tb/implicit_particle_drag_update_test.sv]
// Top of the drag update testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module implicit_particle_drag_update_test;
  import ipdu_pkg::*;
  import ipdu_tb_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [30:0] cfg_data;
  logic        in_took;
  int          errors;
  int          pending;
  int          idle_cycles;

  ipdu_stream_if #(.Width(ParticleBits)) in_ch ();
  ipdu_stream_if #(.Width(ResultBits)) out_ch ();

  implicit_particle_drag_update uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  drag_update_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) in_took <= in_ch.valid && in_ch.ready;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("** implicit_particle_drag_update: FAILED **");
        $finish;
      end
    end
  end

  // The receiver alternates between always-ready stretches and random stalls.
  initial begin
    int run_len;
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 60);
      mode = $urandom_range(0, 2);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic signed [31:0] rand_s32();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [30:0] rand_u31(logic [30:0] lo);
    case ($urandom_range(0, 5))
      0: return 31'h7FFF_FFFF;
      1: return lo;
      2, 3: return lo + 31'($urandom_range(0, 32'h0004_0000));
      default: return 31'($urandom()) | lo;
    endcase
  endfunction

  function automatic particle_t rand_particle(kind_t kind);
    particle_t p;
    p.kind = kind;
    p.drag_coeff = rand_u31(31'd0);
    p.particle_mass = rand_u31(31'd1);
    p.fluid_vel_x = rand_s32();
    p.fluid_vel_y = rand_s32();
    p.fluid_vel_z = rand_s32();
    p.part_vel_x = rand_s32();
    p.part_vel_y = rand_s32();
    p.part_vel_z = rand_s32();
    p.extra_force_x = rand_s32();
    p.extra_force_y = rand_s32();
    p.extra_force_z = rand_s32();
    return p;
  endfunction

  function automatic particle_t uniform_particle(kind_t kind, logic [30:0] coeff,
                                                 logic [30:0] mass, logic signed [31:0] fv,
                                                 logic signed [31:0] pv,
                                                 logic signed [31:0] ef);
    particle_t p;
    p.kind = kind;
    p.drag_coeff = coeff;
    p.particle_mass = mass;
    p.fluid_vel_x = fv;
    p.fluid_vel_y = fv;
    p.fluid_vel_z = fv;
    p.part_vel_x = pv;
    p.part_vel_y = pv;
    p.part_vel_z = pv;
    p.extra_force_x = ef;
    p.extra_force_y = ef;
    p.extra_force_z = ef;
    return p;
  endfunction

  // Leaves valid high so that back-to-back transactions need no gap.
  task automatic send(particle_t p);
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic configure(logic cn, logic [16:0] a, logic [30:0] amf, logic [30:0] hst);
    drain();
    write_reg(REG_USE_CN, {30'd0, cn});
    write_reg(REG_ALPHA, {14'd0, a});
    write_reg(REG_ADDED_MASS, amf);
    write_reg(REG_HALF_STEP, hst);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, logic cn);
    int burst;
    kind_t kind;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        case ($urandom_range(0, 19))
          0: kind = KIND_CLEAR;
          1: kind = KIND_OUTSIDE;
          2, 3, 4: kind = cn ? KIND_EXPLICIT : KIND_IMPLICIT;
          default: kind = cn ? KIND_IMPLICIT : KIND_EXPLICIT;
        endcase
        send(rand_particle(kind));
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 25));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_USE_CN;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(uniform_particle(KIND_CLEAR, 31'd0, 31'd1, 0, 0, 0));
    send(uniform_particle(KIND_EXPLICIT, 31'h7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF));
    send(uniform_particle(KIND_EXPLICIT, 31'h7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF));
    send(uniform_particle(KIND_EXPLICIT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'sh8000_0000));
    send(uniform_particle(KIND_EXPLICIT, 31'd65536, 31'd1, 32'sh0001_0000, 0, 0));
    send(uniform_particle(KIND_IMPLICIT, 31'd65536, 31'd1, 32'sh0001_0000, 0, 0));
    send(uniform_particle(KIND_OUTSIDE, 31'd65536, 31'd1, 32'sh0001_0000, 0, 5));
    send(uniform_particle(KIND_CLEAR, 31'h7FFF_FFFF, 31'h7FFF_FFFF, -1, -1, -1));
    send(uniform_particle(KIND_EXPLICIT, 31'd0, 31'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, -7));

    configure(1'b1, 17'd65536, 31'd65536, 31'd16384);
    send(uniform_particle(KIND_IMPLICIT, 31'd65536, 31'd65536, 32'sh0002_0000, 0, 0));
    send(uniform_particle(KIND_IMPLICIT, 31'h7FFF_FFFF, 31'd1, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 0));
    send(uniform_particle(KIND_IMPLICIT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 0));
    send(uniform_particle(KIND_EXPLICIT, 31'd65536, 31'd1, 32'sh0001_0000, 0,
                          32'sh7FFF_FFFF));
    send(uniform_particle(KIND_OUTSIDE, 31'd65536, 31'd1, 32'sh0001_0000, 0, 0));
    configure(1'b1, 17'h1FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send(uniform_particle(KIND_IMPLICIT, 31'h7FFF_FFFF, 31'd1, 32'sh0100_0000,
                          -32'sh0100_0000, 0));
    send(uniform_particle(KIND_IMPLICIT, 31'd0, 31'd1, 32'sh0100_0000, 32'sh0000_8000, 0));
    send(uniform_particle(KIND_CLEAR, 31'd0, 31'd1, 0, 0, 0));

    configure(1'b0, 17'd0, 31'd65536, 31'd0);
    random_phase(70, 1'b0);
    configure(1'b1, 17'd0, 31'd65536, 31'd65536);
    random_phase(60, 1'b1);
    configure(1'b1, 17'd65536, 31'd131072, 31'd4096);
    random_phase(60, 1'b1);
    configure(1'b1, 17'd32768, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_phase(60, 1'b1);
    configure(1'b1, 17'h1FFFF, 31'd65536, 31'd0);
    random_phase(50, 1'b1);
    configure(1'b1, 17'($urandom_range(0, 65536)), 31'($urandom_range(65536, 32'h7FFF_FFFF)),
              31'($urandom()));
    random_phase(60, 1'b1);
    configure(1'b0, 17'd12345, 31'd98304, 31'd200000);
    random_phase(70, 1'b0);
    configure(1'b1, 17'd49152, 31'd81920, 31'd32768);
    random_phase(70, 1'b1);

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("** implicit_particle_drag_update: PASSED **");
    end else begin
      $display("** implicit_particle_drag_update: FAILED **");
    end
    $finish;
  end

endmodule
